// ===== src/dme_pkg.sv =====
package dme_pkg;

  // Level range of the delta tracker
  localparam logic [5:0] LEVEL_MAX   = 6'd63;
  localparam logic [5:0] LEVEL_START = 6'd32;

  // Most words one sample can produce (final sample plus tail)
  localparam int unsigned MAX_BURST = 5;
  localparam int unsigned BURST_W   = $clog2(MAX_BURST + 1);

  // Words per sample: by bit phase after a final sample, else one or none
  localparam logic [BURST_W-1:0] TAIL_ALIGNED = BURST_W'(4);
  localparam logic [BURST_W-1:0] TAIL_PARTIAL = BURST_W'(5);
  localparam logic [BURST_W-1:0] TAIL_ONE     = BURST_W'(1);
  localparam logic [BURST_W-1:0] TAIL_NONE    = BURST_W'(0);

  typedef struct packed {
    logic signed [15:0] pcm_value;
    logic               final_sample;
  } dme_in_t;

  typedef struct packed {
    logic [7:0] coded_byte;
    logic       stream_end;
  } dme_out_t;

  // One sample's worth of output: only the first word can be nonzero,
  // the rest of a tail is zero padding.
  typedef struct packed {
    logic [7:0]         first_byte;
    logic [BURST_W-1:0] count;
    logic               flush;
  } dme_burst_t;

endpackage

// ===== src/dme_core.sv =====
module dme_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic                wide,
  input  dme_pkg::dme_in_t    sample,
  output dme_pkg::dme_burst_t burst
);

  logic [5:0] lvl_r, lvl_nxt;
  logic [7:0] sh_r, sh_nxt;
  logic [3:0] bm_r, bm_nxt;

  logic [15:0] ofs16;
  logic [7:0]  ofs8;
  logic [16:0] sum16;
  logic [8:0]  sum8;
  logic [6:0]  raw_tgt;
  logic [5:0]  tgt;
  logic        down;
  logic        bit_v;
  logic [5:0]  lvl_step;
  logic [7:0]  sh_new;
  logic [3:0]  bm_new;
  logic        byte_done;
  logic [2:0]  part_amt;
  logic [7:0]  partial;

  always_comb begin
    // offset binary: flip the sign bit
    ofs16   = {~sample.pcm_value[15], sample.pcm_value[14:0]};
    ofs8    = {~sample.pcm_value[7], sample.pcm_value[6:0]};
    sum16   = {1'b0, ofs16} + 17'd512;
    sum8    = {1'b0, ofs8} + 9'd2;
    raw_tgt = wide ? sum16[16:10] : sum8[8:2];
    tgt     = raw_tgt[6] ? dme_pkg::LEVEL_MAX : raw_tgt[5:0];

    down  = (lvl_r > tgt) || (lvl_r == 6'd0 && tgt == 6'd0);
    bit_v = ~down;
    if (down) begin
      lvl_step = (lvl_r == 6'd0) ? 6'd0 : lvl_r - 6'd1;
    end else begin
      lvl_step = (lvl_r == dme_pkg::LEVEL_MAX) ? dme_pkg::LEVEL_MAX : lvl_r + 6'd1;
    end

    sh_new    = {bit_v, sh_r[7:1]};
    bm_new    = bm_r + 4'd1;
    byte_done = (bm_new[2:0] == 3'd0);
    // zero fill of a partial byte shifts the held bits down to bit 0
    part_amt  = 3'(4'd8 - {1'b0, bm_new[2:0]});
    partial   = sh_new >> part_amt;

    burst.flush      = sample.final_sample;
    burst.first_byte = byte_done ? sh_new : partial;
    if (sample.final_sample) begin
      // 1..8 bits into the 16-bit group: one extra padding word
      if (bm_new == 4'd8 || (bm_new[3] == 1'b0 && bm_new[2:0] != 3'd0)) begin
        burst.count = dme_pkg::TAIL_PARTIAL;
      end else begin
        burst.count = dme_pkg::TAIL_ALIGNED;
      end
    end else begin
      burst.count = byte_done ? dme_pkg::TAIL_ONE : dme_pkg::TAIL_NONE;
    end

    lvl_nxt = lvl_r;
    sh_nxt  = sh_r;
    bm_nxt  = bm_r;
    if (step) begin
      if (sample.final_sample) begin
        lvl_nxt = dme_pkg::LEVEL_START;
        sh_nxt  = 8'd0;
        bm_nxt  = 4'd0;
      end else begin
        lvl_nxt = lvl_step;
        sh_nxt  = byte_done ? 8'd0 : sh_new;
        bm_nxt  = bm_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r <= dme_pkg::LEVEL_START;
      sh_r  <= 8'd0;
      bm_r  <= 4'd0;
    end else begin
      lvl_r <= lvl_nxt;
      sh_r  <= sh_nxt;
      bm_r  <= bm_nxt;
    end
  end

  a_byte_clear: assert property (@(posedge clk) disable iff (!rst_n)
    bm_r[2:0] == 3'd0 |-> sh_r == 8'd0)
    else $error("partial byte not cleared on byte boundary");

  a_flush_reset: assert property (@(posedge clk) disable iff (!rst_n)
    step && sample.final_sample |=> lvl_r == dme_pkg::LEVEL_START && bm_r == 4'd0)
    else $error("state not restored after final sample");

endmodule

// ===== src/dme_burst.sv =====
module dme_burst (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  dme_pkg::dme_burst_t burst,
  output logic                free,
  output logic                out_valid,
  input  logic                out_stall,
  output dme_pkg::dme_out_t   out_data
);

  logic [dme_pkg::BURST_W-1:0] rem_r, rem_nxt;
  logic [7:0]                  byte_r, byte_nxt;
  logic                        fin_r, fin_nxt;
  logic                        take;

  assign out_valid           = (rem_r != '0);
  assign take                = out_valid && !out_stall;
  assign free                = !out_valid || (take && rem_r == dme_pkg::BURST_W'(1));
  assign out_data.coded_byte = byte_r;
  assign out_data.stream_end = fin_r && (rem_r == dme_pkg::BURST_W'(1));

  always_comb begin
    rem_nxt  = rem_r;
    byte_nxt = byte_r;
    fin_nxt  = fin_r;
    if (load) begin
      rem_nxt  = burst.count;
      byte_nxt = burst.first_byte;
      fin_nxt  = burst.flush;
    end else if (take) begin
      // words after the first are zero padding
      rem_nxt  = rem_r - dme_pkg::BURST_W'(1);
      byte_nxt = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
      fin_r <= 1'b0;
    end else begin
      rem_r <= rem_nxt;
      fin_r <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= dme_pkg::BURST_W'(dme_pkg::MAX_BURST))
    else $error("burst count out of range");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> free)
    else $error("burst loaded over pending words");

endmodule

// ===== src/one_bit_delta_modulation_encoder.sv =====
// A sample taken into the input register passes through the coder into the
// result word register, from which its first word is offered on the output.
// Throughput: one sample per cycle while the output is not stalled; a word
// leaves every eighth sample. The final sample of a recording yields four or
// five words, one per unstalled cycle; input stalls until the last is taken.
// Reset (rst_n, synchronous): level 32, no partial byte, narrow samples.
module one_bit_delta_modulation_encoder (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  dme_pkg::dme_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output dme_pkg::dme_out_t out_data
);

  // sample width select: 0 = 8-bit, 1 = 16-bit
  logic wide_r;

  // input word register
  logic             in_v_r;
  dme_pkg::dme_in_t in_r;

  logic                free;
  logic                step;
  logic                in_take;
  dme_pkg::dme_burst_t burst;

  // the held word moves into the coder once the output side can take its burst
  assign step     = in_v_r && free;
  assign in_stall = in_v_r && !free;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_r <= 1'b0;
      in_v_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        wide_r <= cfg_wdata;
      end
      if (in_take) begin
        in_v_r <= 1'b1;
      end else if (step) begin
        in_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r <= in_data;
    end
  end

  // level tracking and bit packing
  dme_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .wide   (wide_r),
    .sample (in_r),
    .burst  (burst)
  );

  // result word register, replays zero padding for the tail
  dme_burst u_burst (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .burst     (burst),
    .free      (free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_step_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !step |=> in_v_r && $stable(in_r))
    else $error("held sample lost before coding");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  // Clock, reset and block ports. Every input has a known value from time zero.
  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic              cfg_wdata = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  dme_pkg::dme_in_t  in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  dme_pkg::dme_out_t out_data;

  one_bit_delta_modulation_encoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  // Shadow of the encoder: sample width, tracked level, partial byte and
  // the bit phase within a 16-bit group.
  logic       wide_mode = 1'b0;
  logic [5:0] track_level = dme_pkg::LEVEL_START;
  logic [7:0] pend_bits = 8'd0;
  logic [3:0] bit_phase = 4'd0;

  dme_pkg::dme_out_t coded_words[$];

  // quiet: no gaps and no stalls (tail of the run)
  logic quiet = 1'b0;
  int   fault_count = 0;
  int   words_checked = 0;
  int   samples_sent = 0;
  int   recordings_done = 0;
  int   width_writes = 0;

  // Maps a raw sample to the 6-bit target level in the current width.
  // Narrow mode only looks at the low byte.
  function automatic logic [5:0] target_of(logic [15:0] raw);
    logic [16:0] acc;
    if (wide_mode) begin
      acc = ({1'b0, raw ^ 16'h8000} + 17'd512) >> 10;
    end else begin
      acc = ({9'd0, raw[7:0] ^ 8'h80} + 17'd2) >> 2;
    end
    return (acc > {11'd0, dme_pkg::LEVEL_MAX}) ? dme_pkg::LEVEL_MAX : acc[5:0];
  endfunction

  // One delta step toward target; the bit lands at the top of the partial
  // byte, which is queued as a word once eight bits are in.
  function automatic void shift_delta(logic [5:0] target);
    logic              dbit;
    dme_pkg::dme_out_t w;
    // both at zero counts as "down" so silence codes as 0 bits
    if (track_level > target || (track_level == 6'd0 && target == 6'd0)) begin
      dbit = 1'b0;
      if (track_level != 6'd0) track_level = track_level - 6'd1;
    end else begin
      dbit = 1'b1;
      if (track_level != dme_pkg::LEVEL_MAX) track_level = track_level + 6'd1;
    end
    pend_bits = {dbit, pend_bits[7:1]};
    bit_phase = bit_phase + 4'd1;
    if (bit_phase[2:0] == 3'd0) begin
      w.coded_byte = pend_bits;
      w.stream_end = 1'b0;
      coded_words = {coded_words, w};
      pend_bits = 8'd0;
    end
  endfunction

  // Expected words for one accepted sample. A final sample is followed by
  // zero-level padding up to the next 16-bit boundary plus 24 bits; the last
  // padded word carries the end flag and the shadow returns to reset.
  function automatic void encode_sample(dme_pkg::dme_in_t s);
    logic [3:0] to_boundary;
    int         prior;
    prior = coded_words.size();
    shift_delta(target_of(s.pcm_value));
    if (s.final_sample) begin
      to_boundary = 4'd0 - bit_phase;
      for (int k = 0; k < int'(to_boundary) + 24; k++) shift_delta(6'd0);
      if (coded_words.size() > prior) coded_words[coded_words.size() - 1].stream_end = 1'b1;
      track_level = dme_pkg::LEVEL_START;
      pend_bits = 8'd0;
      bit_phase = 4'd0;
    end
  endfunction

  function automatic void log_fault(string what);
    fault_count++;
    if (fault_count <= 10) $display("[%0t] mismatch: %s", $realtime, what);
  endfunction

  // Checker: inputs are predicted at the edge they are taken, outputs are
  // compared against the oldest pending word. Both read pre-edge values.
  always @(posedge clk) begin
    dme_pkg::dme_out_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) encode_sample(in_data);
      if (out_valid && !out_stall) begin
        words_checked++;
        if (coded_words.size() == 0) begin
          log_fault($sformatf("unexpected word byte=%02h end=%b",
                              out_data.coded_byte, out_data.stream_end));
        end else begin
          want = coded_words.pop_front();
          if (out_data.coded_byte !== want.coded_byte ||
              out_data.stream_end !== want.stream_end) begin
            log_fault($sformatf("byte exp %02h got %02h, end exp %b got %b",
                                want.coded_byte, out_data.coded_byte,
                                want.stream_end, out_data.stream_end));
          end
        end
      end
    end
  end

  // Output back-pressure: randomly drawn stretches of free flow and stall,
  // off entirely once quiet is set.
  int stall_left = 0;
  always @(posedge clk) begin
    if (quiet) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else if ($urandom_range(0, 2) == 0) begin
      stall_left = $urandom_range(0, 15);
      out_stall <= 1'b1;
    end else begin
      stall_left = $urandom_range(0, 23);
      out_stall <= 1'b0;
    end
  end

  // Sends one sample word, with an occasional idle burst before it. Leaves
  // in_valid high on return so back-to-back words need no extra edge.
  task automatic send_sample(logic [15:0] value, logic last_flag);
    dme_pkg::dme_in_t s;
    int               gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s.pcm_value = value;
    s.final_sample = last_flag;
    in_valid <= 1'b1;
    in_data <= s;
    do @(posedge clk); while (!(in_valid && !in_stall));
    samples_sent++;
    if (last_flag) recordings_done++;
  endtask

  // Holds off the input until every predicted word has come out, then lets
  // the pipeline settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (coded_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_width(logic wide);
    wait_idle();
    cfg_wdata <= wide;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    wide_mode = wide;
    width_writes++;
  endtask

  // Narrow limits, plus upper bits that must be ignored in narrow mode.
  task automatic test_narrow_extremes();
    write_width(1'b0);
    send_sample(16'hFF80, 1'b0);  // -128
    send_sample(16'h007F, 1'b0);  // +127, target saturates
    send_sample(16'h007F, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hFFFF, 1'b0);  // -1
    send_sample(16'h7F80, 1'b0);  // junk above a -128 low byte
    send_sample(16'h817F, 1'b1);  // junk above +127, closes recording
  endtask

  // Final on the very first bit, and final completing a byte.
  task automatic test_tail_phases();
    send_sample(16'h0040, 1'b1);
    for (int k = 0; k < 7; k++) send_sample(16'($urandom), 1'b0);
    send_sample(16'($urandom), 1'b1);
  endtask

  // Wide limits, then a width switch in the middle of a recording.
  task automatic test_wide_extremes();
    write_width(1'b1);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0000, 1'b0);
    write_width(1'b0);
    send_sample(16'hFF80, 1'b0);
    send_sample(16'h007F, 1'b1);
  endtask

  // Random recordings of random length and flavor: full-range noise, runs
  // pinned at either extreme (drives the level to its clamps and into the
  // both-zero case), or values hovering near the midpoint.
  task automatic test_random_recordings(int n_items);
    int          sent;
    int          len;
    int          flavor;
    logic [15:0] value;
    sent = 0;
    while (sent < n_items) begin
      // the last stretch runs with no gaps and no stalls
      if (sent >= n_items - 30) quiet = 1'b1;
      if (!quiet && $urandom_range(0, 2) == 0) write_width(1'($urandom_range(0, 1)));
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 70) : $urandom_range(1, 24);
      if (len > n_items - sent) len = n_items - sent;
      flavor = $urandom_range(0, 3);
      for (int k = 0; k < len; k++) begin
        value = 16'($urandom);
        if ($urandom_range(0, 4) != 0) begin
          case (flavor)
            1: value = wide_mode ? 16'h8000 : {value[15:8], 8'h80};
            2: value = wide_mode ? 16'h7FFF : {value[15:8], 8'h7F};
            3: value = wide_mode ? {{6{value[9]}}, value[9:0]}
                                 : {value[15:8], {5{value[2]}}, value[2:0]};
            default: ;
          endcase
        end
        send_sample(value, k == len - 1);
        sent++;
      end
    end
  endtask

  initial begin
    int drain_wait;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_narrow_extremes();
    test_tail_phases();
    test_wide_extremes();
    test_random_recordings(128);

    quiet = 1'b1;
    in_valid <= 1'b0;
    drain_wait = 0;
    while (coded_words.size() != 0 && drain_wait < 5000) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (10) @(posedge clk);
    if (coded_words.size() != 0) begin
      log_fault($sformatf("%0d words never came out", coded_words.size()));
    end

    $display("Coded %0d samples in %0d recordings over %0d width settings.",
             samples_sent, recordings_done, width_writes);
    $display("Compared %0d output words; %0d faults.", words_checked, fault_count);
    if (fault_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== one_bit_delta_modulation_encoder.f =====
src/dme_pkg.sv
src/dme_core.sv
src/dme_burst.sv
src/one_bit_delta_modulation_encoder.sv
test/tb_top.sv
